// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL of the tangent frame block.
// No dependencies; simulation builds get the checks, synthesis builds get nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define TTF_ASSERT_ALWAYS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("tangent frame check failed");
`define TTF_ASSERT_NEXT(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("tangent frame check failed");
`else
`define TTF_ASSERT_ALWAYS(lbl, clk, rst, expr)
`define TTF_ASSERT_NEXT(lbl, clk, rst, pre, post)
`endif
`endif

// File: rtl/ttf_pkg.sv
// Shared widths, sequencer states and control types of the tangent frame block.
// No dependencies; used by the interfaces, the multiply unit and the top level.
package ttf_pkg;

   localparam int COORD_W            = 32;
   localparam int DIFF_W             = 33;
   localparam int FIELD_W            = 16;
   localparam int UNIT_FRAC_BITS_DEF = 14;
   localparam int NORM_BITS          = 30;
   localparam int OP_W               = 34;
   localparam int HALF_W             = 17;
   localparam int ACC_W              = 70;
   localparam int ROOT_W             = 62;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DET,
      ST_DET_CHK,
      ST_VEC,
      ST_VEC_ST,
      ST_LOAD,
      ST_SHIFT,
      ST_SQ,
      ST_ROOT0,
      ST_ROOT,
      ST_DIV0,
      ST_DIV,
      ST_OUT
   } ttf_state_type;

   typedef enum logic [1:0] {
      PASS_TAN,
      PASS_BIN,
      PASS_NRM
   } ttf_pass_type;

   typedef struct packed {
      logic       clear;
      logic       en;
      logic       neg;
      logic [1:0] phase;
   } ttf_mac_ctl_type;

endpackage

// File: rtl/ttf_req_if.sv
// Vertex input channel: valid/ready handshake with one vertex per item.
// Depends on ttf_pkg for the coordinate width.
interface ttf_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [ttf_pkg::COORD_W-1:0] pos_x;
   logic signed [ttf_pkg::COORD_W-1:0] pos_y;
   logic signed [ttf_pkg::COORD_W-1:0] pos_z;
   logic signed [ttf_pkg::COORD_W-1:0] tex_u;
   logic signed [ttf_pkg::COORD_W-1:0] tex_v;
   logic                                mesh_start;

   modport source (output valid, pos_x, pos_y, pos_z, tex_u, tex_v, mesh_start,
                   input ready);
   modport sink (input valid, pos_x, pos_y, pos_z, tex_u, tex_v, mesh_start,
                 output ready);
endinterface

// File: rtl/ttf_rsp_if.sv
// Result channel: valid/ready handshake with one tangent frame per item.
// Depends on ttf_pkg for the field width.
interface ttf_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [ttf_pkg::FIELD_W-1:0] tangent_x;
   logic signed [ttf_pkg::FIELD_W-1:0] tangent_y;
   logic signed [ttf_pkg::FIELD_W-1:0] tangent_z;
   logic signed [ttf_pkg::FIELD_W-1:0] binormal_x;
   logic signed [ttf_pkg::FIELD_W-1:0] binormal_y;
   logic signed [ttf_pkg::FIELD_W-1:0] binormal_z;
   logic signed [ttf_pkg::FIELD_W-1:0] normal_x;
   logic signed [ttf_pkg::FIELD_W-1:0] normal_y;
   logic signed [ttf_pkg::FIELD_W-1:0] normal_z;
   logic                                degenerate;

   modport source (output valid, tangent_x, tangent_y, tangent_z, binormal_x, binormal_y,
                   binormal_z, normal_x, normal_y, normal_z, degenerate,
                   input ready);
   modport sink (input valid, tangent_x, tangent_y, tangent_z, binormal_x, binormal_y,
                 binormal_z, normal_x, normal_y, normal_z, degenerate,
                 output ready);
endinterface

// File: rtl/ttf_mac.sv
// Shared signed multiply-accumulate unit: one 17x17 partial product per cycle.
// Depends on ttf_pkg; a full 34x34 product takes four phases.
module ttf_mac (
   input  logic                                clock,
   input  ttf_pkg::ttf_mac_ctl_type            ctl,
   input  logic signed [ttf_pkg::OP_W-1:0]     op_a,
   input  logic signed [ttf_pkg::OP_W-1:0]     op_b,
   output logic signed [ttf_pkg::ACC_W-1:0]    acc
);

   logic [ttf_pkg::OP_W-1:0]       mag_a;
   logic [ttf_pkg::OP_W-1:0]       mag_b;
   logic [ttf_pkg::HALF_W-1:0]     part_a;
   logic [ttf_pkg::HALF_W-1:0]     part_b;
   logic [2*ttf_pkg::HALF_W-1:0]   pp;
   logic [ttf_pkg::ACC_W-1:0]      term;
   logic signed [ttf_pkg::ACC_W-1:0] base;
   logic signed [ttf_pkg::ACC_W-1:0] acc_ff;
   logic signed [ttf_pkg::ACC_W-1:0] acc_in;
   logic                           subtract;

   always_comb begin
      mag_a  = op_a[ttf_pkg::OP_W-1] ? -op_a : op_a;
      mag_b  = op_b[ttf_pkg::OP_W-1] ? -op_b : op_b;
      part_a = ctl.phase[1] ? mag_a[ttf_pkg::OP_W-1:ttf_pkg::HALF_W]
                            : mag_a[ttf_pkg::HALF_W-1:0];
      part_b = ctl.phase[0] ? mag_b[ttf_pkg::OP_W-1:ttf_pkg::HALF_W]
                            : mag_b[ttf_pkg::HALF_W-1:0];
      pp     = part_a * part_b;
      term   = ttf_pkg::ACC_W'(pp);
      if (ctl.phase[1]) begin
         term = term << ttf_pkg::HALF_W;
      end
      if (ctl.phase[0]) begin
         term = term << ttf_pkg::HALF_W;
      end
      subtract = op_a[ttf_pkg::OP_W-1] ^ op_b[ttf_pkg::OP_W-1] ^ ctl.neg;
      base     = ctl.clear ? '0 : acc_ff;
      acc_in   = acc_ff;
      if (ctl.en) begin
         acc_in = subtract ? base - $signed(term) : base + $signed(term);
      end else if (ctl.clear) begin
         acc_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign acc = acc_ff;

endmodule

// File: rtl/triangle_tangent_frame_core.sv
// Per-triangle tangent frame: the first two corners are only stored; the third corner
// starts the determinant and then the tangent, binormal and normal passes, each with
// its normalizing shift (the passes are skipped when the texture is degenerate).
// The single 17x17 multiply-accumulate unit, the bit-per-cycle square root and the
// divider do this work in turn; no vertex is accepted meanwhile.
// Synchronous active-high reset clears the corner count, sequencer and result valid.
`include "assert_macros.svh"

module triangle_tangent_frame_core #(
   parameter int UNIT_FRAC_BITS = ttf_pkg::UNIT_FRAC_BITS_DEF
) (
   input logic        clock,
   input logic        reset,
   ttf_req_if.sink    req_ch,
   ttf_rsp_if.source  rsp_ch
);

   localparam int UW      = UNIT_FRAC_BITS + 2;
   localparam int DW      = UNIT_FRAC_BITS + ttf_pkg::NORM_BITS + 2;
   localparam int CW      = $clog2(UNIT_FRAC_BITS + 1);
   localparam int CWD     = ttf_pkg::COORD_W;
   localparam int EW      = ttf_pkg::DIFF_W;
   localparam int AW      = ttf_pkg::ACC_W;
   localparam int RW      = ttf_pkg::ROOT_W;
   localparam int NB      = ttf_pkg::NORM_BITS;
   localparam int FW      = ttf_pkg::FIELD_W;
   localparam logic [UNIT_FRAC_BITS:0] QUO_MAX = {1'b1, {UNIT_FRAC_BITS{1'b0}}};

   ttf_pkg::ttf_state_type state_ff, state_in;
   ttf_pkg::ttf_pass_type  pass_ff, pass_in;
   logic [1:0]             corner_ff, corner_in;
   logic [1:0]             comp_ff, comp_in;
   logic [1:0]             term_ff, term_in;
   logic [1:0]             phase_ff, phase_in;
   logic                   det_neg_ff, det_neg_in;
   logic                   deg_ff, deg_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   logic signed [CWD-1:0]  held_pos_ff [6];
   logic signed [CWD-1:0]  held_pos_in [6];
   logic signed [CWD-1:0]  held_tex_ff [4];
   logic signed [CWD-1:0]  held_tex_in [4];
   logic signed [EW-1:0]   e1_ff [3];
   logic signed [EW-1:0]   e1_in [3];
   logic signed [EW-1:0]   e2_ff [3];
   logic signed [EW-1:0]   e2_in [3];
   logic signed [EW-1:0]   du1_ff, du1_in, dv1_ff, dv1_in;
   logic signed [EW-1:0]   du2_ff, du2_in, dv2_ff, dv2_in;
   logic signed [AW-1:0]   vec_ff [3];
   logic signed [AW-1:0]   vec_in [3];
   logic [AW-1:0]          mag_ff [3];
   logic [AW-1:0]          mag_in [3];
   logic                   sgn_ff [3];
   logic                   sgn_in [3];
   logic [RW-1:0]          root_x_ff, root_x_in;
   logic [RW-1:0]          root_r_ff, root_r_in;
   logic [RW-1:0]          root_bit_ff, root_bit_in;
   logic [DW-1:0]          rem_ff, rem_in;
   logic [DW-1:0]          dvs_ff, dvs_in;
   logic [UNIT_FRAC_BITS:0] quo_ff, quo_in;
   logic [CW-1:0]          cnt_ff, cnt_in;
   logic signed [UW-1:0]   unit_ff [3][3];
   logic signed [UW-1:0]   unit_in [3][3];
   logic signed [FW-1:0]   out_ff [9];
   logic signed [FW-1:0]   out_in [9];
   logic                   out_deg_ff, out_deg_in;

   ttf_pkg::ttf_mac_ctl_type mac_ctl;
   logic signed [ttf_pkg::OP_W-1:0] op_a, op_b;
   logic signed [AW-1:0]   acc;

   logic                   accept;
   logic                   third_accept;
   logic [1:0]             corner_idx;
   logic signed [CWD-1:0]  in_pos [3];
   logic [AW-1:0]          or_all;
   logic [1:0]             nrm_i, nrm_j;
   logic [1:0]             last_term;
   logic                   pass_done;
   logic [RW-1:0]          root_try;
   logic                   div_ge;
   logic [UNIT_FRAC_BITS:0] quo_next;
   logic [UW-1:0]          quo_ext;
   logic                   rsp_load;

   ttf_mac u_mac (
      .clock (clock),
      .ctl   (mac_ctl),
      .op_a  (op_a),
      .op_b  (op_b),
      .acc   (acc)
   );

   assign in_pos[0] = req_ch.pos_x;
   assign in_pos[1] = req_ch.pos_y;
   assign in_pos[2] = req_ch.pos_z;

   assign req_ch.ready = (state_ff == ttf_pkg::ST_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;
   assign corner_idx   = req_ch.mesh_start ? 2'd0 : corner_ff;
   assign third_accept = accept && corner_idx[1];

   assign or_all   = mag_ff[0] | mag_ff[1] | mag_ff[2];
   assign root_try = root_r_ff + root_bit_ff;
   assign div_ge   = (rem_ff >= dvs_ff);
   assign quo_next = {quo_ff[UNIT_FRAC_BITS-1:0], div_ge};
   assign quo_ext  = UW'(quo_next);

   // Normal pass crosses component i = comp+1 and j = comp+2 (mod 3).
   always_comb begin
      case (comp_ff)
         2'd0: begin
            nrm_i = 2'd1;
            nrm_j = 2'd2;
         end
         2'd1: begin
            nrm_i = 2'd2;
            nrm_j = 2'd0;
         end
         default: begin
            nrm_i = 2'd0;
            nrm_j = 2'd1;
         end
      endcase
   end

   // Operand selection for the shared multiply unit.
   always_comb begin
      op_a          = '0;
      op_b          = '0;
      mac_ctl.neg   = term_ff[0] && (state_ff != ttf_pkg::ST_SQ);
      mac_ctl.phase = phase_ff;
      mac_ctl.en    = (state_ff == ttf_pkg::ST_DET) || (state_ff == ttf_pkg::ST_VEC) ||
                      (state_ff == ttf_pkg::ST_SQ);
      mac_ctl.clear = mac_ctl.en && (term_ff == 2'd0) && (phase_ff == 2'd0);
      case (state_ff)
         ttf_pkg::ST_DET: begin
            op_a = term_ff[0] ? ttf_pkg::OP_W'(dv1_ff) : ttf_pkg::OP_W'(du1_ff);
            op_b = term_ff[0] ? ttf_pkg::OP_W'(du2_ff) : ttf_pkg::OP_W'(dv2_ff);
         end
         ttf_pkg::ST_VEC: begin
            case (pass_ff)
               ttf_pkg::PASS_TAN: begin
                  op_a = term_ff[0] ? ttf_pkg::OP_W'(dv1_ff) : ttf_pkg::OP_W'(dv2_ff);
                  op_b = term_ff[0] ? ttf_pkg::OP_W'(e2_ff[comp_ff])
                                    : ttf_pkg::OP_W'(e1_ff[comp_ff]);
               end
               ttf_pkg::PASS_BIN: begin
                  op_a = term_ff[0] ? ttf_pkg::OP_W'(du2_ff) : ttf_pkg::OP_W'(du1_ff);
                  op_b = term_ff[0] ? ttf_pkg::OP_W'(e1_ff[comp_ff])
                                    : ttf_pkg::OP_W'(e2_ff[comp_ff]);
               end
               default: begin
                  op_a = term_ff[0] ? ttf_pkg::OP_W'(unit_ff[0][nrm_j])
                                    : ttf_pkg::OP_W'(unit_ff[0][nrm_i]);
                  op_b = term_ff[0] ? ttf_pkg::OP_W'(unit_ff[1][nrm_i])
                                    : ttf_pkg::OP_W'(unit_ff[1][nrm_j]);
               end
            endcase
         end
         ttf_pkg::ST_SQ: begin
            op_a = ttf_pkg::OP_W'(mag_ff[term_ff][NB-1:0]);
            op_b = ttf_pkg::OP_W'(mag_ff[term_ff][NB-1:0]);
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   // Sequencer: next state and datapath updates.
   always_comb begin
      state_in     = state_ff;
      pass_in      = pass_ff;
      corner_in    = corner_ff;
      comp_in      = comp_ff;
      term_in      = term_ff;
      phase_in     = phase_ff;
      det_neg_in   = det_neg_ff;
      deg_in       = deg_ff;
      held_pos_in  = held_pos_ff;
      held_tex_in  = held_tex_ff;
      e1_in        = e1_ff;
      e2_in        = e2_ff;
      du1_in       = du1_ff;
      dv1_in       = dv1_ff;
      du2_in       = du2_ff;
      dv2_in       = dv2_ff;
      vec_in       = vec_ff;
      mag_in       = mag_ff;
      sgn_in       = sgn_ff;
      root_x_in    = root_x_ff;
      root_r_in    = root_r_ff;
      root_bit_in  = root_bit_ff;
      rem_in       = rem_ff;
      dvs_in       = dvs_ff;
      quo_in       = quo_ff;
      cnt_in       = cnt_ff;
      unit_in      = unit_ff;
      out_in       = out_ff;
      out_deg_in   = out_deg_ff;
      pass_done    = 1'b0;
      rsp_load     = 1'b0;
      last_term    = (state_ff == ttf_pkg::ST_SQ) ? 2'd2 : 2'd1;

      case (state_ff)
         ttf_pkg::ST_IDLE: begin
            if (accept) begin
               if (!corner_idx[1]) begin
                  for (int k = 0; k < 3; k++) begin
                     held_pos_in[{corner_idx[0], 1'b0} + corner_idx + 3'(k)] = in_pos[k];
                  end
                  held_tex_in[{corner_idx[0], 1'b0}]       = req_ch.tex_u;
                  held_tex_in[{corner_idx[0], 1'b0} + 2'd1] = req_ch.tex_v;
                  corner_in = corner_idx + 2'd1;
               end else begin
                  for (int k = 0; k < 3; k++) begin
                     e1_in[k] = EW'(held_pos_ff[3 + k]) - EW'(held_pos_ff[k]);
                     e2_in[k] = EW'(in_pos[k]) - EW'(held_pos_ff[k]);
                  end
                  du1_in    = EW'(held_tex_ff[2]) - EW'(held_tex_ff[0]);
                  dv1_in    = EW'(held_tex_ff[3]) - EW'(held_tex_ff[1]);
                  du2_in    = EW'(req_ch.tex_u) - EW'(held_tex_ff[0]);
                  dv2_in    = EW'(req_ch.tex_v) - EW'(held_tex_ff[1]);
                  corner_in = 2'd0;
                  term_in   = 2'd0;
                  phase_in  = 2'd0;
                  state_in  = ttf_pkg::ST_DET;
               end
            end
         end
         ttf_pkg::ST_DET, ttf_pkg::ST_VEC, ttf_pkg::ST_SQ: begin
            phase_in = phase_ff + 2'd1;
            if (phase_ff == 2'd3) begin
               if (term_ff == last_term) begin
                  term_in = 2'd0;
                  case (state_ff)
                     ttf_pkg::ST_DET: state_in = ttf_pkg::ST_DET_CHK;
                     ttf_pkg::ST_VEC: state_in = ttf_pkg::ST_VEC_ST;
                     default:         state_in = ttf_pkg::ST_ROOT0;
                  endcase
               end else begin
                  term_in = term_ff + 2'd1;
               end
            end
         end
         ttf_pkg::ST_DET_CHK: begin
            if (acc == '0) begin
               deg_in   = 1'b1;
               state_in = ttf_pkg::ST_OUT;
            end else begin
               deg_in     = 1'b0;
               det_neg_in = acc[AW-1];
               pass_in    = ttf_pkg::PASS_TAN;
               comp_in    = 2'd0;
               term_in    = 2'd0;
               phase_in   = 2'd0;
               state_in   = ttf_pkg::ST_VEC;
            end
         end
         ttf_pkg::ST_VEC_ST: begin
            // Tangent and binormal take the sign of the texture determinant.
            vec_in[comp_ff] = (pass_ff != ttf_pkg::PASS_NRM && det_neg_ff) ? -acc : acc;
            if (comp_ff == 2'd2) begin
               comp_in  = 2'd0;
               state_in = ttf_pkg::ST_LOAD;
            end else begin
               comp_in  = comp_ff + 2'd1;
               state_in = ttf_pkg::ST_VEC;
            end
         end
         ttf_pkg::ST_LOAD: begin
            for (int k = 0; k < 3; k++) begin
               sgn_in[k] = vec_ff[k][AW-1];
               mag_in[k] = vec_ff[k][AW-1] ? -vec_ff[k] : vec_ff[k];
            end
            if (vec_ff[0] == '0 && vec_ff[1] == '0 && vec_ff[2] == '0) begin
               for (int k = 0; k < 3; k++) begin
                  unit_in[pass_ff][k] = '0;
               end
               pass_done = 1'b1;
            end else begin
               state_in = ttf_pkg::ST_SHIFT;
            end
         end
         ttf_pkg::ST_SHIFT: begin
            // Bring the largest magnitude into [2^29, 2^30); right shifts truncate.
            if (or_all[AW-1:NB+8] != '0) begin
               for (int k = 0; k < 3; k++) mag_in[k] = mag_ff[k] >> 8;
            end else if (or_all[AW-1:NB] != '0) begin
               for (int k = 0; k < 3; k++) mag_in[k] = mag_ff[k] >> 1;
            end else if (or_all[AW-1:NB-9] == '0) begin
               for (int k = 0; k < 3; k++) mag_in[k] = mag_ff[k] << 8;
            end else if (!or_all[NB-1]) begin
               for (int k = 0; k < 3; k++) mag_in[k] = mag_ff[k] << 1;
            end else begin
               term_in  = 2'd0;
               phase_in = 2'd0;
               state_in = ttf_pkg::ST_SQ;
            end
         end
         ttf_pkg::ST_ROOT0: begin
            root_x_in   = acc[RW-1:0];
            root_r_in   = '0;
            root_bit_in = RW'(1) << (RW - 2);
            state_in    = ttf_pkg::ST_ROOT;
         end
         ttf_pkg::ST_ROOT: begin
            if (root_x_ff >= root_try) begin
               root_x_in = root_x_ff - root_try;
               root_r_in = (root_r_ff >> 1) + root_bit_ff;
            end else begin
               root_r_in = root_r_ff >> 1;
            end
            root_bit_in = root_bit_ff >> 2;
            if (root_bit_ff[0]) begin
               comp_in  = 2'd0;
               state_in = ttf_pkg::ST_DIV0;
            end
         end
         ttf_pkg::ST_DIV0: begin
            // Rounded quotient: (c * 2^U + len/2) / len, one bit per cycle.
            rem_in   = (DW'(mag_ff[comp_ff][NB-1:0]) << UNIT_FRAC_BITS) +
                       DW'(root_r_ff >> 1);
            dvs_in   = DW'(root_r_ff) << UNIT_FRAC_BITS;
            quo_in   = '0;
            cnt_in   = CW'(UNIT_FRAC_BITS);
            state_in = ttf_pkg::ST_DIV;
         end
         ttf_pkg::ST_DIV: begin
            if (div_ge) begin
               rem_in = rem_ff - dvs_ff;
            end
            dvs_in = dvs_ff >> 1;
            quo_in = quo_next;
            cnt_in = cnt_ff - CW'(1);
            if (cnt_ff == '0) begin
               unit_in[pass_ff][comp_ff] = sgn_ff[comp_ff] ? -quo_ext : quo_ext;
               if (comp_ff == 2'd2) begin
                  pass_done = 1'b1;
               end else begin
                  comp_in  = comp_ff + 2'd1;
                  state_in = ttf_pkg::ST_DIV0;
               end
            end
         end
         ttf_pkg::ST_OUT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_load = 1'b1;
               for (int k = 0; k < 3; k++) begin
                  out_in[k]     = deg_ff ? '0 : FW'(unit_ff[0][k]);
                  out_in[3 + k] = deg_ff ? '0 : FW'(unit_ff[1][k]);
                  out_in[6 + k] = deg_ff ? '0 : FW'(unit_ff[2][k]);
               end
               out_deg_in = deg_ff;
               state_in   = ttf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ttf_pkg::ST_IDLE;
         end
      endcase

      if (pass_done) begin
         if (pass_ff == ttf_pkg::PASS_NRM) begin
            state_in = ttf_pkg::ST_OUT;
         end else begin
            pass_in  = (pass_ff == ttf_pkg::PASS_TAN) ? ttf_pkg::PASS_BIN : ttf_pkg::PASS_NRM;
            comp_in  = 2'd0;
            term_in  = 2'd0;
            phase_in = 2'd0;
            state_in = ttf_pkg::ST_VEC;
         end
      end

      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ch.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ttf_pkg::ST_IDLE;
         corner_ff    <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         corner_ff    <= corner_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pass_ff     <= pass_in;
      comp_ff     <= comp_in;
      term_ff     <= term_in;
      phase_ff    <= phase_in;
      det_neg_ff  <= det_neg_in;
      deg_ff      <= deg_in;
      held_pos_ff <= held_pos_in;
      held_tex_ff <= held_tex_in;
      e1_ff       <= e1_in;
      e2_ff       <= e2_in;
      du1_ff      <= du1_in;
      dv1_ff      <= dv1_in;
      du2_ff      <= du2_in;
      dv2_ff      <= dv2_in;
      vec_ff      <= vec_in;
      mag_ff      <= mag_in;
      sgn_ff      <= sgn_in;
      root_x_ff   <= root_x_in;
      root_r_ff   <= root_r_in;
      root_bit_ff <= root_bit_in;
      rem_ff      <= rem_in;
      dvs_ff      <= dvs_in;
      quo_ff      <= quo_in;
      cnt_ff      <= cnt_in;
      unit_ff     <= unit_in;
      out_ff      <= out_in;
      out_deg_ff  <= out_deg_in;
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.tangent_x  = out_ff[0];
   assign rsp_ch.tangent_y  = out_ff[1];
   assign rsp_ch.tangent_z  = out_ff[2];
   assign rsp_ch.binormal_x = out_ff[3];
   assign rsp_ch.binormal_y = out_ff[4];
   assign rsp_ch.binormal_z = out_ff[5];
   assign rsp_ch.normal_x   = out_ff[6];
   assign rsp_ch.normal_y   = out_ff[7];
   assign rsp_ch.normal_z   = out_ff[8];
   assign rsp_ch.degenerate = out_deg_ff;

   `TTF_ASSERT_ALWAYS(a_corner_range, clock, reset, corner_ff != 2'd3)
   `TTF_ASSERT_NEXT(a_third_starts, clock, reset, third_accept, state_ff == ttf_pkg::ST_DET)
   `TTF_ASSERT_ALWAYS(a_normalized, clock, reset,
      state_ff != ttf_pkg::ST_SQ || (or_all[AW-1:NB] == '0 && or_all[NB-1]))
   `TTF_ASSERT_ALWAYS(a_quo_bound, clock, reset,
      state_ff != ttf_pkg::ST_DIV || cnt_ff != '0 || quo_next <= QUO_MAX)

endmodule
